// File: rtl/rv32i_integer_execute_macros.svh
// ----------------------------------------------------------------------------
// RV32I integer execute - assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef RV32I_INTEGER_EXECUTE_MACROS_SVH
`define RV32I_INTEGER_EXECUTE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RV32IE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RV32IE_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rv32ie_pkg.sv
// ----------------------------------------------------------------------------
// RV32I integer execute - package
// Operation codes, decoded micro-op and result types shared by all modules but the RAM.
// ----------------------------------------------------------------------------
package rv32ie_pkg;

	localparam int XLEN     = 32;
	localparam int RF_DEPTH = 32;
	localparam int IDX_W    = 5;
	localparam int IMM_W    = 20;

	typedef enum logic [4:0] {
		OP_ADDI  = 5'd0,
		OP_SLTI  = 5'd1,
		OP_SLTIU = 5'd2,
		OP_XORI  = 5'd3,
		OP_ORI   = 5'd4,
		OP_ANDI  = 5'd5,
		OP_SLLI  = 5'd6,
		OP_SRLI  = 5'd7,
		OP_SRAI  = 5'd8,
		OP_ADD   = 5'd9,
		OP_SUB   = 5'd10,
		OP_SLL   = 5'd11,
		OP_SLT   = 5'd12,
		OP_SLTU  = 5'd13,
		OP_XOR   = 5'd14,
		OP_SRL   = 5'd15,
		OP_SRA   = 5'd16,
		OP_OR    = 5'd17,
		OP_AND   = 5'd18,
		OP_LUI   = 5'd19,
		OP_AUIPC = 5'd20,
		OP_JAL   = 5'd21,
		OP_JALR  = 5'd22,
		OP_BEQ   = 5'd23,
		OP_BNE   = 5'd24,
		OP_BLT   = 5'd25,
		OP_BGE   = 5'd26,
		OP_BLTU  = 5'd27,
		OP_BGEU  = 5'd28
	} op_t;

	typedef enum logic [2:0] {
		CLS_NOP,
		CLS_ALU,
		CLS_LUI,
		CLS_AUIPC,
		CLS_JAL,
		CLS_JALR,
		CLS_BRANCH
	} cls_t;

	typedef enum logic [3:0] {
		FN_ADD,
		FN_SUB,
		FN_SLL,
		FN_SLT,
		FN_SLTU,
		FN_XOR,
		FN_SRL,
		FN_SRA,
		FN_OR,
		FN_AND
	} alu_fn_t;

	typedef enum logic [2:0] {
		BR_EQ,
		BR_NE,
		BR_LT,
		BR_GE,
		BR_LTU,
		BR_GEU
	} br_fn_t;

	typedef struct packed {
		cls_t              cls;
		alu_fn_t           fn;
		br_fn_t            br;
		logic              use_imm;
		logic              wen;
		logic [IDX_W-1:0]  rd;
		logic [IDX_W-1:0]  rs1;
		logic [IDX_W-1:0]  rs2;
		logic [XLEN-1:0]   imm;
	} uop_t;

	typedef struct packed {
		logic [XLEN-1:0]   next_pc;
		logic              wen;
		logic [IDX_W-1:0]  idx;
		logic [XLEN-1:0]   value;
	} res_t;

endpackage

// File: rtl/rv32ie_ram.sv
// ----------------------------------------------------------------------------
// RV32I integer execute - generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module rv32ie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/rv32ie_front.sv
// ----------------------------------------------------------------------------
// RV32I integer execute - front end
// Accepts instructions, decodes them into micro-ops and queues them.
// ----------------------------------------------------------------------------
module rv32ie_front import rv32ie_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [4:0]       op,
	input  logic [IDX_W-1:0] dest_index,
	input  logic [IDX_W-1:0] src1_index,
	input  logic [IDX_W-1:0] src2_index,
	input  logic [IMM_W-1:0] imm_bits,
	input  logic             deq,
	output logic             head_valid,
	output uop_t             head
);

	uop_t       uop;
	uop_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push_ok;
	logic       writes;

	logic [XLEN-1:0] imm12;
	logic [XLEN-1:0] shamt;
	logic [XLEN-1:0] upper;
	logic [XLEN-1:0] jofs;
	logic [XLEN-1:0] bofs;

	assign imm12 = {{(XLEN-12){imm_bits[11]}}, imm_bits[11:0]};
	assign shamt = {{(XLEN-5){1'b0}}, imm_bits[4:0]};
	assign upper = {imm_bits, 12'b0};
	assign jofs  = {{(XLEN-IMM_W){imm_bits[IMM_W-1]}}, imm_bits};
	assign bofs  = {{(XLEN-13){imm_bits[12]}}, imm_bits[12:0]};

	always_comb begin
		uop         = '0;
		uop.cls     = CLS_ALU;
		uop.fn      = FN_ADD;
		uop.br      = BR_EQ;
		uop.use_imm = 1'b1;
		uop.rd      = dest_index;
		uop.rs1     = src1_index;
		uop.rs2     = src2_index;
		uop.imm     = imm12;
		writes      = 1'b1;
		case (op_t'(op))
			OP_ADDI:  uop.fn = FN_ADD;
			OP_SLTI:  uop.fn = FN_SLT;
			OP_SLTIU: uop.fn = FN_SLTU;
			OP_XORI:  uop.fn = FN_XOR;
			OP_ORI:   uop.fn = FN_OR;
			OP_ANDI:  uop.fn = FN_AND;
			OP_SLLI: begin
				uop.fn  = FN_SLL;
				uop.imm = shamt;
			end
			OP_SRLI: begin
				uop.fn  = FN_SRL;
				uop.imm = shamt;
			end
			OP_SRAI: begin
				uop.fn  = FN_SRA;
				uop.imm = shamt;
			end
			OP_ADD: begin
				uop.fn      = FN_ADD;
				uop.use_imm = 1'b0;
			end
			OP_SUB: begin
				uop.fn      = FN_SUB;
				uop.use_imm = 1'b0;
			end
			OP_SLL: begin
				uop.fn      = FN_SLL;
				uop.use_imm = 1'b0;
			end
			OP_SLT: begin
				uop.fn      = FN_SLT;
				uop.use_imm = 1'b0;
			end
			OP_SLTU: begin
				uop.fn      = FN_SLTU;
				uop.use_imm = 1'b0;
			end
			OP_XOR: begin
				uop.fn      = FN_XOR;
				uop.use_imm = 1'b0;
			end
			OP_SRL: begin
				uop.fn      = FN_SRL;
				uop.use_imm = 1'b0;
			end
			OP_SRA: begin
				uop.fn      = FN_SRA;
				uop.use_imm = 1'b0;
			end
			OP_OR: begin
				uop.fn      = FN_OR;
				uop.use_imm = 1'b0;
			end
			OP_AND: begin
				uop.fn      = FN_AND;
				uop.use_imm = 1'b0;
			end
			OP_LUI: begin
				uop.cls = CLS_LUI;
				uop.imm = upper;
			end
			OP_AUIPC: begin
				uop.cls = CLS_AUIPC;
				uop.imm = upper;
			end
			OP_JAL: begin
				uop.cls = CLS_JAL;
				uop.imm = jofs;
			end
			OP_JALR:  uop.cls = CLS_JALR;
			OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
				uop.cls = CLS_BRANCH;
				uop.imm = bofs;
				writes  = 1'b0;
				case (op_t'(op))
					OP_BEQ:  uop.br = BR_EQ;
					OP_BNE:  uop.br = BR_NE;
					OP_BLT:  uop.br = BR_LT;
					OP_BGE:  uop.br = BR_GE;
					OP_BLTU: uop.br = BR_LTU;
					default: uop.br = BR_GEU;
				endcase
			end
			default: begin
				uop.cls = CLS_NOP;
				writes  = 1'b0;
			end
		endcase
		// A write to x0 is dropped here, so the back end never sees it.
		uop.wen = writes && (dest_index != '0);
	end

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];
	assign push_ok    = push && !full;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= uop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push_ok} - {1'b0, deq};
		end
	end

endmodule

// File: rtl/rv32ie_outq.sv
// ----------------------------------------------------------------------------
// RV32I integer execute - result queue
// Two-entry queue that holds finished results until they are popped.
// ----------------------------------------------------------------------------
module rv32ie_outq import rv32ie_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  res_t wdata,
	output logic full,
	input  logic pop,
	output logic empty,
	output res_t head
);

	res_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       rd;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];
	assign rd    = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

// File: rtl/rv32ie_back.sv
// ----------------------------------------------------------------------------
// RV32I integer execute - back end
// Reads the register file and updates the pc; one micro-op per cycle unless res_full.
// ----------------------------------------------------------------------------
module rv32ie_back import rv32ie_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  uop_t head,
	output logic deq,
	input  logic res_full,
	output logic res_wr,
	output res_t res
);

	logic            valid_s2;
	uop_t            uop_s2;
	logic            v1_s2;
	logic            v2_s2;
	logic [XLEN-1:0] pc_q;
	logic [RF_DEPTH-1:0] rf_valid_q;
	logic            byp_en_q;
	logic [IDX_W-1:0] byp_idx_q;
	logic [XLEN-1:0] byp_val_q;

	logic            issue;
	logic            commit;
	logic [XLEN-1:0] rdata1;
	logic [XLEN-1:0] rdata2;
	logic [XLEN-1:0] a;
	logic [XLEN-1:0] b;
	logic [XLEN-1:0] b_op;
	logic [XLEN-1:0] alu_res;
	logic [XLEN-1:0] tgt;
	logic [XLEN-1:0] pc_plus4;
	logic [XLEN-1:0] value;
	logic [XLEN-1:0] next;
	logic            taken;
	logic            lt_s;
	logic            lt_u;

	assign commit = valid_s2 && !res_full;
	assign issue  = head_valid && (!valid_s2 || commit);
	assign deq    = issue;

	rv32ie_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_rf_a (
		.clk   (clk),
		.we    (commit && uop_s2.wen),
		.waddr (uop_s2.rd),
		.wdata (value),
		.re    (issue),
		.raddr (head.rs1),
		.rdata (rdata1)
	);

	rv32ie_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_rf_b (
		.clk   (clk),
		.we    (commit && uop_s2.wen),
		.waddr (uop_s2.rd),
		.wdata (value),
		.re    (issue),
		.raddr (head.rs2),
		.rdata (rdata2)
	);

	// The RAM returns old data when the previous instruction writes the
	// register in the same cycle as the read, so that write is forwarded.
	always_comb begin
		a = v1_s2 ? rdata1 : '0;
		b = v2_s2 ? rdata2 : '0;
		if (byp_en_q && (byp_idx_q == uop_s2.rs1)) begin
			a = byp_val_q;
		end
		if (byp_en_q && (byp_idx_q == uop_s2.rs2)) begin
			b = byp_val_q;
		end
	end

	assign b_op     = uop_s2.use_imm ? uop_s2.imm : b;
	assign lt_s     = $signed(a) < $signed(b_op);
	assign lt_u     = a < b_op;
	assign pc_plus4 = pc_q + XLEN'(4);
	assign tgt      = ((uop_s2.cls == CLS_JALR) ? a : pc_q) + uop_s2.imm;

	always_comb begin
		case (uop_s2.fn)
			FN_ADD:  alu_res = a + b_op;
			FN_SUB:  alu_res = a - b_op;
			FN_SLL:  alu_res = a << b_op[4:0];
			FN_SLT:  alu_res = {{(XLEN-1){1'b0}}, lt_s};
			FN_SLTU: alu_res = {{(XLEN-1){1'b0}}, lt_u};
			FN_XOR:  alu_res = a ^ b_op;
			FN_SRL:  alu_res = a >> b_op[4:0];
			FN_SRA:  alu_res = $unsigned($signed(a) >>> b_op[4:0]);
			FN_OR:   alu_res = a | b_op;
			FN_AND:  alu_res = a & b_op;
			default: alu_res = a & b_op;
		endcase
	end

	always_comb begin
		case (uop_s2.br)
			BR_EQ:   taken = (a == b);
			BR_NE:   taken = (a != b);
			BR_LT:   taken = $signed(a) < $signed(b);
			BR_GE:   taken = !($signed(a) < $signed(b));
			BR_LTU:  taken = a < b;
			BR_GEU:  taken = !(a < b);
			default: taken = 1'b0;
		endcase
	end

	always_comb begin
		value = '0;
		next  = pc_plus4;
		case (uop_s2.cls)
			CLS_ALU:    value = alu_res;
			CLS_LUI:    value = uop_s2.imm;
			CLS_AUIPC:  value = tgt;
			CLS_JAL: begin
				value = pc_plus4;
				next  = tgt;
			end
			CLS_JALR: begin
				value = pc_plus4;
				next  = {tgt[XLEN-1:1], 1'b0};
			end
			CLS_BRANCH: begin
				if (taken) begin
					next = tgt;
				end
			end
			default:    next = pc_plus4;
		endcase
	end

	assign res_wr      = commit;
	assign res.next_pc = next;
	assign res.wen     = uop_s2.wen;
	assign res.idx     = uop_s2.wen ? uop_s2.rd : '0;
	assign res.value   = uop_s2.wen ? value : '0;

	always_ff @(posedge clk) begin
		if (issue) begin
			uop_s2 <= head;
			v1_s2  <= rf_valid_q[head.rs1];
			v2_s2  <= rf_valid_q[head.rs2];
		end
		if (commit) begin
			byp_idx_q <= uop_s2.rd;
			byp_val_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			pc_q       <= '0;
			rf_valid_q <= '0;
			byp_en_q   <= 1'b0;
		end else begin
			if (issue) begin
				valid_s2 <= 1'b1;
			end else if (commit) begin
				valid_s2 <= 1'b0;
			end
			if (commit) begin
				pc_q     <= next;
				byp_en_q <= uop_s2.wen;
				if (uop_s2.wen) begin
					rf_valid_q[uop_s2.rd] <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/rv32i_integer_execute.sv
// ----------------------------------------------------------------------------
// RV32I integer execute unit
// Executes decoded RV32I integer instructions against a register file and pc.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake    Payload
// input    in   push / full  op, dest_index, src1_index, src2_index, imm_bits
// result   out  pop / empty  next_pc, write_enable, write_index, write_value
//
// One instruction per cycle is sustained while the result queue has room;
// the pc update in the execute stage is the loop that sets this rate.
// A result passes the instruction queue, execute stage and result queue.
// Reset clears the pc and the register file valid bits at once; no sweep.
// A stalled result side fills the two-entry result queue, then the execute
// stage, then the two-entry instruction queue, after which full rises.
module rv32i_integer_execute import rv32ie_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [4:0]       op,
	input  logic [IDX_W-1:0] dest_index,
	input  logic [IDX_W-1:0] src1_index,
	input  logic [IDX_W-1:0] src2_index,
	input  logic [IMM_W-1:0] imm_bits,
	output logic             empty,
	input  logic             pop,
	output logic [XLEN-1:0]  next_pc,
	output logic             write_enable,
	output logic [IDX_W-1:0] write_index,
	output logic [XLEN-1:0]  write_value
);

	logic head_valid;
	uop_t head;
	logic deq;
	logic res_full;
	logic res_wr;
	res_t res;
	res_t res_head;

	rv32ie_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.dest_index (dest_index),
		.src1_index (src1_index),
		.src2_index (src2_index),
		.imm_bits   (imm_bits),
		.deq        (deq),
		.head_valid (head_valid),
		.head       (head)
	);

	rv32ie_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.deq        (deq),
		.res_full   (res_full),
		.res_wr     (res_wr),
		.res        (res)
	);

	rv32ie_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.head   (res_head)
	);

	assign next_pc      = res_head.next_pc;
	assign write_enable = res_head.wen;
	assign write_index  = res_head.idx;
	assign write_value  = res_head.value;

endmodule

// File: rtl/rv32ie_checker.sv
// ----------------------------------------------------------------------------
// RV32I integer execute - port checker
// Watches the top level ports for write-back consistency and result holding.
// ----------------------------------------------------------------------------
`include "rv32i_integer_execute_macros.svh"

module rv32ie_checker import rv32ie_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input logic [XLEN-1:0]  next_pc,
	input logic             write_enable,
	input logic [IDX_W-1:0] write_index,
	input logic [XLEN-1:0]  write_value
);

	// A result without a write carries a zero index and a zero value.
	`RV32IE_ASSERT_IMP(a_nowrite_zero, clk, arst_n, !empty && !write_enable, (write_index == '0) && (write_value == '0), "write fields not cleared")

	// x0 is never reported as written.
	`RV32IE_ASSERT_IMP(a_no_x0_write, clk, arst_n, !empty && write_enable, write_index != '0, "write to x0 reported")

	// A result that is not taken stays on the ports unchanged.
	`RV32IE_ASSERT_NXT(a_result_holds, clk, arst_n, !empty && !pop, !empty && $stable(next_pc) && $stable(write_enable) && $stable(write_index) && $stable(write_value), "waiting result changed")

endmodule

bind rv32i_integer_execute rv32ie_checker u_checker (.*);

// File: tb/rv32ie_execute_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I integer execute - result checker
// Watches the instruction and result channels, keeps a shadow register file
// and pc, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module rv32ie_execute_checker import rv32ie_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             full,
	input  logic [4:0]       op,
	input  logic [IDX_W-1:0] dest_index,
	input  logic [IDX_W-1:0] src1_index,
	input  logic [IDX_W-1:0] src2_index,
	input  logic [IMM_W-1:0] imm_bits,
	input  logic             empty,
	input  logic             pop,
	input  logic [XLEN-1:0]  next_pc,
	input  logic             write_enable,
	input  logic [IDX_W-1:0] write_index,
	input  logic [XLEN-1:0]  write_value,
	output int               fail_count,
	output int               pending,
	output int               checked,
	output int               taken_branches
);

	logic [XLEN-1:0] shadow_regs [RF_DEPTH];
	logic [XLEN-1:0] shadow_pc;
	res_t            results_due [$];
	int              errors;
	int              matched;
	int              taken_total;

	// Executes one instruction on the shadow state and returns its result beat.
	function automatic res_t execute_instr(input logic [4:0] opc,
		input logic [IDX_W-1:0] rd, input logic [IDX_W-1:0] rs1,
		input logic [IDX_W-1:0] rs2, input logic [IMM_W-1:0] imm,
		output logic taken);
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
		logic [XLEN-1:0] imm_i;
		logic [XLEN-1:0] imm_b;
		logic [XLEN-1:0] imm_j;
		logic [XLEN-1:0] value;
		logic [XLEN-1:0] target;
		logic            wr;
		res_t            r;
		a      = shadow_regs[rs1];
		b      = shadow_regs[rs2];
		imm_i  = {{20{imm[11]}}, imm[11:0]};
		imm_b  = {{19{imm[12]}}, imm[12:0]};
		imm_j  = {{12{imm[19]}}, imm};
		target = shadow_pc + 32'd4;
		value  = '0;
		wr     = 1'b1;
		taken  = 1'b0;
		case (opc)
		OP_ADDI:  value = a + imm_i;
		OP_SLTI:  value = ($signed(a) < $signed(imm_i)) ? 32'd1 : 32'd0;
		OP_SLTIU: value = (a < imm_i) ? 32'd1 : 32'd0;
		OP_XORI:  value = a ^ imm_i;
		OP_ORI:   value = a | imm_i;
		OP_ANDI:  value = a & imm_i;
		OP_SLLI:  value = a << imm[4:0];
		OP_SRLI:  value = a >> imm[4:0];
		OP_SRAI:  value = $unsigned($signed(a) >>> imm[4:0]);
		OP_ADD:   value = a + b;
		OP_SUB:   value = a - b;
		OP_SLL:   value = a << b[4:0];
		OP_SLT:   value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
		OP_SLTU:  value = (a < b) ? 32'd1 : 32'd0;
		OP_XOR:   value = a ^ b;
		OP_SRL:   value = a >> b[4:0];
		OP_SRA:   value = $unsigned($signed(a) >>> b[4:0]);
		OP_OR:    value = a | b;
		OP_AND:   value = a & b;
		OP_LUI:   value = {imm, 12'd0};
		OP_AUIPC: value = shadow_pc + {imm, 12'd0};
		OP_JAL: begin
			value  = shadow_pc + 32'd4;
			target = shadow_pc + imm_j;
		end
		OP_JALR: begin
			value  = shadow_pc + 32'd4;
			target = (a + imm_i) & ~32'd1;
		end
		OP_BEQ: begin
			wr    = 1'b0;
			taken = (a == b);
		end
		OP_BNE: begin
			wr    = 1'b0;
			taken = (a != b);
		end
		OP_BLT: begin
			wr    = 1'b0;
			taken = ($signed(a) < $signed(b));
		end
		OP_BGE: begin
			wr    = 1'b0;
			taken = ($signed(a) >= $signed(b));
		end
		OP_BLTU: begin
			wr    = 1'b0;
			taken = (a < b);
		end
		OP_BGEU: begin
			wr    = 1'b0;
			taken = (a >= b);
		end
		default: wr = 1'b0;
		endcase
		if (taken) begin
			target = shadow_pc + imm_b;
		end
		// Writes to x0 vanish and leave the write fields all zero.
		if (wr && rd != '0) begin
			shadow_regs[rd] = value;
		end else begin
			wr    = 1'b0;
			rd    = '0;
			value = '0;
		end
		shadow_pc = target;
		r.next_pc = target;
		r.wen     = wr;
		r.idx     = rd;
		r.value   = value;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		logic took;
		if (!arst_n) begin
			foreach (shadow_regs[i]) begin
				shadow_regs[i] = '0;
			end
			shadow_pc = '0;
			results_due.delete();
		end else begin
			// A result beat always belongs to an older instruction, so it is
			// checked before this edge's instruction beat is predicted.
			if (pop && !empty) begin
				got.next_pc = next_pc;
				got.wen     = write_enable;
				got.idx     = write_index;
				got.value   = write_value;
				if (results_due.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: result beat with nothing outstanding: pc %h we %b idx %0d val %h",
							$realtime, got.next_pc, got.wen, got.idx, got.value);
					end
				end else begin
					want = results_due.pop_front();
					if (got.next_pc !== want.next_pc || got.wen !== want.wen ||
						got.idx !== want.idx || got.value !== want.value) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: result mismatch", $realtime);
							$display("  next_pc      exp %h got %h", want.next_pc, got.next_pc);
							$display("  write_enable exp %b got %b", want.wen, got.wen);
							$display("  write_index  exp %0d got %0d", want.idx, got.idx);
							$display("  write_value  exp %h got %h", want.value, got.value);
						end
					end else begin
						matched++;
					end
				end
			end
			if (push && !full) begin
				want = execute_instr(op, dest_index, src1_index, src2_index, imm_bits, took);
				results_due.push_back(want);
				if (took) begin
					taken_total++;
				end
			end
		end
		fail_count     <= errors;
		pending        <= results_due.size();
		checked        <= matched;
		taken_branches <= taken_total;
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I integer execute - testbench
// Drives directed and random instruction beats with random idling on both
// channels; the checker predicts every result and reports mismatches.
// ----------------------------------------------------------------------------
module testbench import rv32ie_pkg::*; ();

	localparam logic [4:0] OP_SPARE_LO = 5'd29;
	localparam logic [4:0] OP_SPARE_HI = 5'd31;
	localparam int         RANDOM_ITEMS = 600;
	localparam int         STALL_LIMIT  = 2000;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             push         = 1'b0;
	logic             full;
	logic [4:0]       op           = '0;
	logic [IDX_W-1:0] dest_index   = '0;
	logic [IDX_W-1:0] src1_index   = '0;
	logic [IDX_W-1:0] src2_index   = '0;
	logic [IMM_W-1:0] imm_bits     = '0;
	logic             empty;
	logic             pop          = 1'b0;
	logic [XLEN-1:0]  next_pc;
	logic             write_enable;
	logic [IDX_W-1:0] write_index;
	logic [XLEN-1:0]  write_value;

	int   fail_count;
	int   pending;
	int   checked;
	int   taken_branches;
	int   sent    = 0;
	logic no_gaps = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	rv32i_integer_execute u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.op           (op),
		.dest_index   (dest_index),
		.src1_index   (src1_index),
		.src2_index   (src2_index),
		.imm_bits     (imm_bits),
		.empty        (empty),
		.pop          (pop),
		.next_pc      (next_pc),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_value  (write_value)
	);

	rv32ie_execute_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.op             (op),
		.dest_index     (dest_index),
		.src1_index     (src1_index),
		.src2_index     (src2_index),
		.imm_bits       (imm_bits),
		.empty          (empty),
		.pop            (pop),
		.next_pc        (next_pc),
		.write_enable   (write_enable),
		.write_index    (write_index),
		.write_value    (write_value),
		.fail_count     (fail_count),
		.pending        (pending),
		.checked        (checked),
		.taken_branches (taken_branches)
	);

	// The result side stalls at random except during the no-idle stretch.
	always @(posedge clk) begin
		pop <= no_gaps || ($urandom_range(99) >= 37);
	end

	// Holds one instruction beat until it is accepted; push stays high after
	// acceptance so that back-to-back beats need no toggle.
	task automatic send_instr(input logic [4:0] opc, input logic [IDX_W-1:0] rd,
		input logic [IDX_W-1:0] rs1, input logic [IDX_W-1:0] rs2,
		input logic [IMM_W-1:0] imm);
		while (!no_gaps && $urandom_range(99) < 37) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push       <= 1'b1;
		op         <= opc;
		dest_index <= rd;
		src1_index <= rs1;
		src2_index <= rs2;
		imm_bits   <= imm;
		do @(posedge clk); while (full);
		sent++;
	endtask

	initial begin
		int               stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) begin
				stall = 0;
			end else begin
				stall++;
			end
		end
		$display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [4:0]       opc;
		logic [IDX_W-1:0] rd;
		logic [IDX_W-1:0] rs1;
		logic [IDX_W-1:0] rs2;
		logic [IMM_W-1:0] imm;
		int               directed;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Build extreme operands first: x1 = INT_MIN, x2 = INT_MAX, x3 = 0x7ff,
		// x4 = all ones. Upper immediate bits that an op ignores are set.
		send_instr(OP_LUI,   1, 0, 0, 20'h80000);
		send_instr(OP_ADDI,  2, 1, 0, 20'hFFFFF);
		send_instr(OP_ADDI,  3, 0, 0, 20'h007FF);
		send_instr(OP_XORI,  4, 0, 0, 20'h00FFF);
		send_instr(OP_ADDI,  0, 4, 0, 20'h00005);
		send_instr(OP_SLTI,  5, 1, 0, 20'h00800);
		send_instr(OP_SLTIU, 6, 2, 0, 20'h00800);
		send_instr(OP_ORI,   7, 1, 0, 20'h0F0F0);
		send_instr(OP_ANDI,  8, 4, 0, 20'hA5A5A);
		send_instr(OP_SLLI,  9, 4, 0, 20'hFFFFF);
		send_instr(OP_SRLI, 10, 1, 0, 20'hFFFE0);
		send_instr(OP_SRAI, 11, 1, 0, 20'h0001F);
		send_instr(OP_ADD,  12, 2, 4, 20'h00000);
		send_instr(OP_SUB,  13, 0, 1, 20'h00000);
		send_instr(OP_SLL,  14, 4, 4, 20'h00000);
		send_instr(OP_SLT,  15, 1, 2, 20'h00000);
		send_instr(OP_SLTU, 16, 1, 2, 20'h00000);
		send_instr(OP_SRA,  17, 1, 3, 20'h00000);
		send_instr(OP_SRL,  18, 1, 4, 20'h00000);
		send_instr(OP_XOR,  19, 1, 4, 20'h00000);
		send_instr(OP_OR,   20, 1, 2, 20'h00000);
		send_instr(OP_AND,  21, 4, 2, 20'h00000);
		send_instr(OP_AUIPC, 22, 0, 0, 20'hFFFFF);
		// Most negative jump offset wraps the pc; an odd offset is also sent.
		send_instr(OP_JAL,  23, 0, 0, 20'h80000);
		send_instr(OP_JAL,   0, 0, 0, 20'h7FFFF);
		// jalr to an odd address clears bit 0.
		send_instr(OP_JALR, 24, 3, 0, 20'h00000);
		send_instr(OP_JALR,  0, 1, 0, 20'h00800);
		send_instr(OP_BEQ,   0, 0, 0, 20'h01000);
		send_instr(OP_BNE,   5, 1, 2, 20'h00FFF);
		send_instr(OP_BLT,   0, 1, 2, 20'h00010);
		send_instr(OP_BGE,   0, 1, 2, 20'h00010);
		send_instr(OP_BLTU,  0, 1, 2, 20'hFFFF0);
		send_instr(OP_BGEU,  0, 4, 1, 20'h00008);
		send_instr(OP_SPARE_LO, 25, 4, 4, 20'hFFFFF);
		send_instr(OP_SPARE_HI, 26, 1, 2, 20'h12345);
		directed = sent;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			no_gaps = (n >= 250 && n < 400);
			opc = 5'($urandom_range(OP_SPARE_HI));
			rd  = IDX_W'($urandom);
			rs1 = IDX_W'($urandom);
			rs2 = ($urandom_range(7) == 0) ? rs1 : IDX_W'($urandom);
			case ($urandom_range(7))
			0: imm = '0;
			1: imm = '1;
			2: imm = 20'h00800;
			3: imm = 20'h01000;
			default: imm = IMM_W'($urandom);
			endcase
			send_instr(opc, rd, rs1, rs2, imm);
		end
		no_gaps = 1'b0;
		push <= 1'b0;

		// Let the outstanding count take in the last accepted beat first.
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		$display("Sent %0d instructions (%0d directed, %0d random); %0d results matched.",
			sent, directed, sent - directed, checked);
		$display("%0d branches were taken; a stretch of 150 beats ran with no idling.",
			taken_branches);
		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
